@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hw/rtl/dts_pkg.sv @@
// ----------------------------------------------------------------------------
// dts_pkg
// types, register codes and constants of the delay trend slope estimator
// ----------------------------------------------------------------------------
package dts_pkg;

    // window depth default
    localparam int MAX_WINDOW_DEF = 64;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_COEF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT    = 2'd3;

    localparam logic [15:0] RST_SMOOTHING_COEF = 16'd58982;
    localparam logic [15:0] RST_THRESHOLD_GAIN = 16'd1024;
    localparam logic [6:0]  RST_WINDOW_LENGTH  = 7'd20;
    localparam logic [15:0] RST_COUNT_LIMIT    = 16'd1000;

    // slope saturation bounds
    localparam logic [31:0] SLOPE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SLOPE_MIN = 32'h8000_0000;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QLW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [15:0] smoothing_coef;
        logic [15:0] threshold_gain;
        logic [6:0]  window_length;
        logic [15:0] count_limit;
        logic        win_wr;
    } cfg_t;

    typedef struct packed {
        logic [32:0] diff;
        logic [47:0] x_off;
        logic [15:0] count;
    } q_entry_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] p;
    } mul_rsp_t;

endpackage

@@ hw/rtl/delay_trendline_slope_estimator_top.sv @@
// ----------------------------------------------------------------------------
// delay_trendline_slope_estimator_top
// least-squares delay trend slope over a ring of smoothed packet-group delays
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    recv_spacing, send_spacing, arrival_time
//   out      output     out_valid/out_ready  scaled_slope, slope_valid, delta_count
//   cfg      input      cfg_wr_en            cfg_index, cfg_wdata
//
// an item takes longer once the ring is full than while it fills (less
// when the fit has zero x variance or saturates), set by the shared 64 x 64
// multiplier (up to nine products) and the 32-step quotient loop
// the front queues up to two items, so items are taken while the back works
// a finished result waits in the output register without stopping the queue
// reset is asynchronous and active low; the ring needs no clearing pass
// ----------------------------------------------------------------------------
module delay_trendline_slope_estimator_top
    import dts_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           recv_spacing,
    input  logic [31:0]           send_spacing,
    input  logic [47:0]           arrival_time,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           scaled_slope,
    output logic                  slope_valid,
    output logic [15:0]           delta_count,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [15:0] smoothing_coef_reg;
    logic [15:0] threshold_gain_reg;
    logic [6:0]  window_length_reg;
    logic [15:0] count_limit_reg;

    cfg_t     cfg;
    q_entry_t push_data;
    q_entry_t pop_data;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;
    mul_req_t mreq;
    mul_rsp_t mrsp;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothing_coef_reg <= RST_SMOOTHING_COEF;
            threshold_gain_reg <= RST_THRESHOLD_GAIN;
            window_length_reg  <= RST_WINDOW_LENGTH;
            count_limit_reg    <= RST_COUNT_LIMIT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SMOOTHING_COEF: smoothing_coef_reg <= cfg_wdata[15:0];
                REG_THRESHOLD_GAIN: threshold_gain_reg <= cfg_wdata[15:0];
                REG_WINDOW_LENGTH:  window_length_reg  <= cfg_wdata[6:0];
                REG_COUNT_LIMIT:    count_limit_reg    <= cfg_wdata[15:0];
                default:            count_limit_reg    <= count_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.smoothing_coef = smoothing_coef_reg;
        cfg.threshold_gain = threshold_gain_reg;
        cfg.window_length  = window_length_reg;
        cfg.count_limit    = count_limit_reg;
        cfg.win_wr         = cfg_wr_en && (cfg_index == REG_WINDOW_LENGTH);
    end

    dts_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .recv_spacing (recv_spacing),
        .send_spacing (send_spacing),
        .arrival_time (arrival_time),
        .count_limit  (count_limit_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (push_data)
    );

    dts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    dts_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    dts_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_data       (pop_data),
        .mreq         (mreq),
        .mrsp         (mrsp),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scaled_slope (scaled_slope),
        .slope_valid  (slope_valid),
        .delta_count  (delta_count)
    );

endmodule

@@ hw/rtl/dts_front.sv @@
// ----------------------------------------------------------------------------
// dts_front
// accepts items, latches the first arrival, forms the delay difference,
// the arrival offset and the capped delta count, and queues them
// ----------------------------------------------------------------------------
module dts_front
    import dts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] recv_spacing,
    input  logic [31:0] send_spacing,
    input  logic [47:0] arrival_time,
    input  logic [15:0] count_limit,
    input  logic        q_full,
    output logic        q_push,
    output q_entry_t    q_data
);

    logic        first_seen_reg;
    logic [47:0] first_arr_reg;
    logic [15:0] cnt_reg;

    logic [47:0] base;
    logic [16:0] cnt_inc;
    logic [15:0] cnt_next;

    // item classification
    always_comb
    begin
        base     = first_seen_reg ? first_arr_reg : arrival_time;
        cnt_inc  = {1'b0, cnt_reg} + 17'd1;
        cnt_next = (cnt_inc > {1'b0, count_limit}) ? count_limit : cnt_inc[15:0];
        q_data.diff  = {recv_spacing[31], recv_spacing} - {send_spacing[31], send_spacing};
        q_data.x_off = arrival_time - base;
        q_data.count = cnt_next;
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // first arrival and delta counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_seen_reg <= 1'b0;
            first_arr_reg  <= '0;
            cnt_reg        <= '0;
        end
        else if (q_push)
        begin
            first_seen_reg <= 1'b1;
            first_arr_reg  <= base;
            cnt_reg        <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/dts_queue.sv @@
// ----------------------------------------------------------------------------
// dts_queue
// short queue of classified items between the front and the back
// ----------------------------------------------------------------------------
module dts_queue
    import dts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    input  logic     pop,
    output q_entry_t pop_data,
    output logic     full,
    output logic     empty
);

    q_entry_t           entry_reg [QDEPTH];
    logic [QAW-1:0]     wr_ptr_reg;
    logic [QAW-1:0]     rd_ptr_reg;
    logic [QLW-1:0]     level_reg;

    assign full     = (level_reg == QLW'(QDEPTH));
    assign empty    = (level_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/dts_mul.sv @@
// ----------------------------------------------------------------------------
// dts_mul
// shared signed 64 x 64 multiplier, one 32 x 32 partial product a cycle
// ----------------------------------------------------------------------------
module dts_mul
    import dts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [63:0]  ma_reg;
    logic [63:0]  mb_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [2:0]   step_reg;
    logic         busy_reg;
    logic         done_reg;

    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    // partial product for the current step
    always_comb
    begin
        a_part = step_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        b_part = step_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        pp     = a_part * b_part;
        unique case (step_reg[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

    // magnitudes in, four partial steps, sign fix-up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            ma_reg   <= '0;
            mb_reg   <= '0;
            neg_reg  <= 1'b0;
            acc_reg  <= '0;
        end
        else if (req.start)
        begin
            ma_reg   <= req.a[63] ? -req.a : req.a;
            mb_reg   <= req.b[63] ? -req.b : req.b;
            neg_reg  <= req.a[63] ^ req.b[63];
            acc_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (step_reg == 3'd4)
            begin
                acc_reg  <= neg_reg ? -acc_reg : acc_reg;
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                acc_reg  <= acc_reg + pp_sh;
                step_reg <= step_reg + 3'd1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

@@ hw/rtl/dts_back.sv @@
// ----------------------------------------------------------------------------
// dts_back
// sequencer: accumulation, smoothing, history ring, running sums,
// least-squares fit with serial division, gain and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dts_back
    import dts_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_empty,
    output logic        q_pop,
    input  q_entry_t    q_data,
    output mul_req_t    mreq,
    input  mul_rsp_t    mrsp,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] scaled_slope,
    output logic        slope_valid,
    output logic [15:0] delta_count
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int NW = $clog2(MAX_WINDOW + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ACC, S_RDOLD, S_MUL, S_SUMS, S_NUM, S_DEN,
        S_DMAG, S_DBIG, S_DIV, S_OUT
    } state_t;

    typedef enum logic [3:0] {
        M_CS, M_CA, M_XY, M_XX, M_OXY, M_OXX, M_SXY, M_SXX, M_GAIN
    } mop_t;

    state_t state_reg;
    mop_t   mop_reg;
    logic   go_reg;

    // current item
    logic [32:0] diff_reg;
    logic [47:0] x_reg;
    logic [15:0] cnt_reg;

    // filter and ring state
    logic signed [47:0]  acc_reg;
    logic signed [47:0]  smooth_reg;
    logic [AW-1:0]       wpos_reg;
    logic [NW-1:0]       fill_reg;
    logic [95:0]         hist_mem [MAX_WINDOW];
    logic [95:0]         rd_data_reg;

    // running sums and products
    logic signed [47:0]  ox_reg;
    logic signed [47:0]  oy_reg;
    logic                full_reg;
    logic signed [127:0] p1_reg;
    logic signed [127:0] txy_reg;
    logic signed [127:0] txx_reg;
    logic signed [127:0] oxy_reg;
    logic signed [127:0] oxx_reg;
    logic signed [63:0]  sx_reg;
    logic signed [63:0]  sy_reg;
    logic signed [127:0] sxy_reg;
    logic signed [127:0] sxx_reg;
    logic signed [127:0] pa_reg;
    logic signed [127:0] pb_reg;

    // fit and division
    logic signed [127:0] num_reg;
    logic [127:0]        den_reg;
    logic [127:0]        mag_reg;
    logic                neg_reg;
    logic [127:0]        rem_reg;
    logic [31:0]         dlo_reg;
    logic [31:0]         q_reg;
    logic [4:0]          dcnt_reg;
    logic [31:0]         slope_reg;
    logic                valid_reg;

    // result register
    logic        out_valid_reg;
    logic [31:0] out_slope_reg;
    logic        out_flag_reg;
    logic [15:0] out_cnt_reg;
    logic [31:0] scaled_reg;

    logic [15:0]         wl16;
    logic [15:0]         n16;
    logic [NW-1:0]       n_eff;
    logic [AW-1:0]       pos_cur;
    logic [NW-1:0]       pos_inc;
    logic [AW-1:0]       wpos_next;
    logic [NW-1:0]       fill_next;
    logic                full_now;
    logic [49:0]         acc_sum;
    logic signed [47:0]  acc_next;
    logic [127:0]        s_sum;
    logic signed [47:0]  smooth_next;
    logic [127:0]        div_hi;
    logic [128:0]        r2;
    logic                r_ge;
    logic [128:0]        r_sub;
    logic [31:0]         q_fin;
    logic [31:0]         slope_fin;
    logic [31:0]         scaled_next;
    logic                mem_we;
    logic                mem_re;

    // effective window and ring pointers
    always_comb
    begin
        wl16 = {9'd0, cfg.window_length};
        if (wl16 < 16'd2)
        begin
            n16 = 16'd2;
        end
        else if (wl16 > 16'(MAX_WINDOW))
        begin
            n16 = 16'(MAX_WINDOW);
        end
        else
        begin
            n16 = wl16;
        end
        n_eff     = n16[NW-1:0];
        pos_cur   = (NW'(wpos_reg) >= n_eff) ? '0 : wpos_reg;
        pos_inc   = NW'(pos_cur) + NW'(1);
        wpos_next = (pos_inc >= n_eff) ? '0 : pos_inc[AW-1:0];
        full_now  = (fill_reg >= n_eff);
        fill_next = full_now ? fill_reg : fill_reg + NW'(1);
    end

    // saturating accumulation and smoothing
    always_comb
    begin
        acc_sum = {{2{acc_reg[47]}}, acc_reg} + {{17{diff_reg[32]}}, diff_reg};
        if (acc_sum[49:47] == 3'b000 || acc_sum[49:47] == 3'b111)
        begin
            acc_next = acc_sum[47:0];
        end
        else
        begin
            acc_next = acc_sum[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        s_sum       = p1_reg + mrsp.p + 128'd32768;
        smooth_next = s_sum[63:16];
    end

    // division step and slope saturation
    always_comb
    begin
        div_hi = mag_reg >> 24;
        r2     = {rem_reg, dlo_reg[31]};
        r_ge   = (r2 >= {1'b0, den_reg});
        r_sub  = r2 - {1'b0, den_reg};
        q_fin  = {q_reg[30:0], r_ge};
        if (neg_reg)
        begin
            slope_fin = (q_fin > SLOPE_MIN) ? SLOPE_MIN : -q_fin;
        end
        else
        begin
            slope_fin = q_fin[31] ? SLOPE_MAX : q_fin;
        end
        if (mrsp.p[127:39] == '0 || mrsp.p[127:39] == '1)
        begin
            scaled_next = mrsp.p[39:8];
        end
        else
        begin
            scaled_next = mrsp.p[127] ? SLOPE_MIN : SLOPE_MAX;
        end
    end

    // multiplier operand select
    always_comb
    begin
        mreq.start = go_reg && (state_reg == S_MUL);
        unique case (mop_reg)
            M_CS:
            begin
                mreq.a = {48'd0, cfg.smoothing_coef};
                mreq.b = {{16{smooth_reg[47]}}, smooth_reg};
            end
            M_CA:
            begin
                mreq.a = {47'd0, 17'h10000 - {1'b0, cfg.smoothing_coef}};
                mreq.b = {{16{acc_reg[47]}}, acc_reg};
            end
            M_XY:
            begin
                mreq.a = {{16{x_reg[47]}}, x_reg};
                mreq.b = {{16{smooth_reg[47]}}, smooth_reg};
            end
            M_XX:
            begin
                mreq.a = {{16{x_reg[47]}}, x_reg};
                mreq.b = {{16{x_reg[47]}}, x_reg};
            end
            M_OXY:
            begin
                mreq.a = {{16{ox_reg[47]}}, ox_reg};
                mreq.b = {{16{oy_reg[47]}}, oy_reg};
            end
            M_OXX:
            begin
                mreq.a = {{16{ox_reg[47]}}, ox_reg};
                mreq.b = {{16{ox_reg[47]}}, ox_reg};
            end
            M_SXY:
            begin
                mreq.a = sx_reg;
                mreq.b = sy_reg;
            end
            M_SXX:
            begin
                mreq.a = sx_reg;
                mreq.b = sx_reg;
            end
            M_GAIN:
            begin
                mreq.a = {48'd0, cfg.threshold_gain};
                mreq.b = {{32{slope_reg[31]}}, slope_reg};
            end
            default:
            begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    assign q_pop  = (state_reg == S_IDLE) && !q_empty;
    assign mem_re = (state_reg == S_ACC);
    assign mem_we = (state_reg == S_MUL) && (mop_reg == M_CA) && mrsp.done;

    // history ring
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[pos_cur] <= {x_reg, smooth_next};
        end
        if (mem_re)
        begin
            rd_data_reg <= hist_mem[pos_cur];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mop_reg       <= M_CS;
            go_reg        <= 1'b0;
            acc_reg       <= '0;
            smooth_reg    <= '0;
            wpos_reg      <= '0;
            fill_reg      <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            sxy_reg       <= '0;
            sxx_reg       <= '0;
            slope_reg     <= '0;
            valid_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            dcnt_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg.win_wr)
                    begin
                        wpos_reg <= '0;
                        fill_reg <= '0;
                        sx_reg   <= '0;
                        sy_reg   <= '0;
                        sxy_reg  <= '0;
                        sxx_reg  <= '0;
                    end
                    else if (!q_empty)
                    begin
                        diff_reg  <= q_data.diff;
                        x_reg     <= q_data.x_off;
                        cnt_reg   <= q_data.count;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    acc_reg   <= acc_next;
                    state_reg <= S_RDOLD;
                end
                S_RDOLD:
                begin
                    full_reg  <= full_now;
                    ox_reg    <= full_now ? rd_data_reg[95:48] : '0;
                    oy_reg    <= full_now ? rd_data_reg[47:0] : '0;
                    oxy_reg   <= '0;
                    oxx_reg   <= '0;
                    mop_reg   <= M_CS;
                    go_reg    <= 1'b1;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    go_reg <= 1'b0;
                    if (mrsp.done)
                    begin
                        go_reg <= 1'b1;
                        unique case (mop_reg)
                            M_CS:
                            begin
                                p1_reg  <= mrsp.p;
                                mop_reg <= M_CA;
                            end
                            M_CA:
                            begin
                                smooth_reg <= smooth_next;
                                mop_reg    <= M_XY;
                            end
                            M_XY:
                            begin
                                txy_reg <= mrsp.p;
                                mop_reg <= M_XX;
                            end
                            M_XX:
                            begin
                                txx_reg <= mrsp.p;
                                if (full_reg)
                                begin
                                    mop_reg <= M_OXY;
                                end
                                else
                                begin
                                    go_reg    <= 1'b0;
                                    state_reg <= S_SUMS;
                                end
                            end
                            M_OXY:
                            begin
                                oxy_reg <= mrsp.p;
                                mop_reg <= M_OXX;
                            end
                            M_OXX:
                            begin
                                oxx_reg   <= mrsp.p;
                                go_reg    <= 1'b0;
                                state_reg <= S_SUMS;
                            end
                            M_SXY:
                            begin
                                pa_reg  <= mrsp.p;
                                mop_reg <= M_SXX;
                            end
                            M_SXX:
                            begin
                                pb_reg    <= mrsp.p;
                                go_reg    <= 1'b0;
                                state_reg <= S_NUM;
                            end
                            M_GAIN:
                            begin
                                scaled_reg <= scaled_next;
                                go_reg     <= 1'b0;
                                state_reg  <= S_OUT;
                            end
                            default:
                            begin
                                go_reg    <= 1'b0;
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SUMS:
                begin
                    // drop the evicted entry, add the new one
                    sx_reg    <= sx_reg + {{16{x_reg[47]}}, x_reg}
                                 - {{16{ox_reg[47]}}, ox_reg};
                    sy_reg    <= sy_reg + {{16{smooth_reg[47]}}, smooth_reg}
                                 - {{16{oy_reg[47]}}, oy_reg};
                    sxy_reg   <= sxy_reg + txy_reg - oxy_reg;
                    sxx_reg   <= sxx_reg + txx_reg - oxx_reg;
                    wpos_reg  <= wpos_next;
                    fill_reg  <= fill_next;
                    valid_reg <= (fill_next >= n_eff);
                    go_reg    <= 1'b1;
                    state_reg <= S_MUL;
                    mop_reg   <= (fill_next >= n_eff) ? M_SXY : M_GAIN;
                end
                S_NUM:
                begin
                    num_reg   <= $signed({1'b0, n_eff}) * sxy_reg - pa_reg;
                    state_reg <= S_DEN;
                end
                S_DEN:
                begin
                    den_reg   <= $signed({1'b0, n_eff}) * sxx_reg - pb_reg;
                    state_reg <= S_DMAG;
                end
                S_DMAG:
                begin
                    if (den_reg == '0)
                    begin
                        // zero x variance
                        slope_reg <= '0;
                        mop_reg   <= M_GAIN;
                        go_reg    <= 1'b1;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        neg_reg   <= num_reg[127];
                        mag_reg   <= num_reg[127] ? -num_reg : num_reg;
                        state_reg <= S_DBIG;
                    end
                end
                S_DBIG:
                begin
                    if (div_hi >= den_reg)
                    begin
                        // quotient beyond 32 bits
                        slope_reg <= neg_reg ? SLOPE_MIN : SLOPE_MAX;
                        mop_reg   <= M_GAIN;
                        go_reg    <= 1'b1;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        rem_reg   <= div_hi;
                        dlo_reg   <= {mag_reg[23:0], 8'd0};
                        q_reg     <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg  <= r_ge ? r_sub[127:0] : r2[127:0];
                    q_reg    <= q_fin;
                    dlo_reg  <= {dlo_reg[30:0], 1'b0};
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'd31)
                    begin
                        slope_reg <= slope_fin;
                        mop_reg   <= M_GAIN;
                        go_reg    <= 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_slope_reg <= scaled_reg;
                        out_flag_reg  <= valid_reg;
                        out_cnt_reg   <= cnt_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign scaled_slope = out_slope_reg;
    assign slope_valid  = out_flag_reg;
    assign delta_count  = out_cnt_reg;

    // checks
    `AST_IMP(a_mul_done_in_mul, mrsp.done, state_reg == S_MUL)
    `AST_IMP(a_pos_in_window, state_reg == S_IDLE, NW'(wpos_reg) < n_eff)
    `AST_IMP(a_fill_in_window, state_reg != S_SUMS, fill_reg <= n_eff)
    `AST_IMP(a_rem_below_den, state_reg == S_DIV, rem_reg < den_reg)

endmodule

@@ verif/delay_trendline_slope_estimator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delay_trendline_slope_estimator_top_tb
// self-checking bench for the delay trend slope estimator: a directed
// table of items and register writes, then random phases under several
// register settings; results are compared with typed rows or an in-bench predictor
// ----------------------------------------------------------------------------
module delay_trendline_slope_estimator_top_tb;
    import dts_pkg::*;

    localparam int MAXW = 64;

    typedef struct {
        logic [31:0] slope;
        logic        valid;
        logic [15:0] count;
    } slope_result_t;

    typedef struct {
        bit            is_cfg;
        logic [1:0]    idx;
        logic [15:0]   data;
        logic [31:0]   recv;
        logic [31:0]   send;
        logic [47:0]   arrival;
        bit            typed;
        slope_result_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] recv_spacing;
    logic [31:0] send_spacing;
    logic [47:0] arrival_time;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] scaled_slope;
    logic        slope_valid;
    logic [15:0] delta_count;
    logic        cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // predictor state
    logic [15:0]        p_coef;
    logic [15:0]        p_gain;
    logic [6:0]         p_window;
    logic [15:0]        p_limit;
    logic signed [47:0] p_acc;
    logic signed [47:0] p_smooth;
    logic [47:0]        p_first;
    bit                 p_first_seen;
    int unsigned        p_wpos;
    int unsigned        p_fill;
    logic signed [47:0] p_hx [0:MAXW-1];
    logic signed [47:0] p_hy [0:MAXW-1];
    logic signed [31:0] p_fit;
    logic [16:0]        p_seen;

    slope_result_t pending_results [$];
    stim_row_t     stim_table [$];
    int            errors;
    int            items_sent;
    int            results_checked;
    int            cfg_writes;
    int            valid_results;
    bit            quiet;
    int            stall_left;

    delay_trendline_slope_estimator_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .recv_spacing (recv_spacing),
        .send_spacing (send_spacing),
        .arrival_time (arrival_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scaled_slope (scaled_slope),
        .slope_valid  (slope_valid),
        .delta_count  (delta_count),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #30ms;
        $display("end of test: mismatches");
        $finish;
    end

    // register side of the predictor
    task automatic model_reg_write(input logic [1:0] idx, input logic [15:0] data);
        case (idx)
            REG_SMOOTHING_COEF: p_coef = data;
            REG_THRESHOLD_GAIN: p_gain = data;
            REG_WINDOW_LENGTH:
            begin
                p_window = data[6:0];
                p_wpos   = 0;
                p_fill   = 0;
            end
            REG_COUNT_LIMIT:    p_limit = data;
            default: ;
        endcase
    endtask

    // least-squares slope of smoothed delay against arrival offset, Q23.8
    function automatic logic signed [31:0] fit_trend(input int unsigned n);
        logic signed [159:0] sx;
        logic signed [159:0] sy;
        logic signed [159:0] sxy;
        logic signed [159:0] sxx;
        logic signed [159:0] num;
        logic signed [159:0] den;
        logic signed [159:0] quo;
        logic signed [159:0] nn;
        sx  = '0;
        sy  = '0;
        sxy = '0;
        sxx = '0;
        nn  = $signed(160'(n));
        for (int k = 0; k < n; k++)
        begin
            sx  = sx + p_hx[k];
            sy  = sy + p_hy[k];
            sxy = sxy + p_hx[k] * p_hy[k];
            sxx = sxx + p_hx[k] * p_hx[k];
        end
        num = nn * sxy - sx * sy;
        den = nn * sxx - sx * sx;
        if (den == 0)
            return '0;
        quo = (num * 160'sd256) / den;
        if (quo > 160'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (quo < -160'sd2147483648)
            return 32'sh8000_0000;
        return quo[31:0];
    endfunction

    // one item through the predictor, returns the expected result
    task automatic trend_predict(input logic [31:0] recv, input logic [31:0] send,
                                 input logic [47:0] arr, output slope_result_t res);
        logic signed [49:0] acc_next;
        logic signed [81:0] mix;
        logic signed [63:0] scaled;
        logic [47:0]        xoff;
        int unsigned        n;
        int unsigned        pos;
        n = (p_window < 2) ? 2 : ((p_window > MAXW) ? MAXW : p_window);
        p_seen = (p_seen + 17'd1 > {1'b0, p_limit}) ? {1'b0, p_limit} : p_seen + 17'd1;
        if (!p_first_seen)
        begin
            p_first      = arr;
            p_first_seen = 1'b1;
        end
        acc_next = p_acc + $signed(recv) - $signed(send);
        if (acc_next > 50'sh7FFF_FFFF_FFFF)
            acc_next = 50'sh7FFF_FFFF_FFFF;
        else if (acc_next < -50'sh8000_0000_0000)
            acc_next = -50'sh8000_0000_0000;
        p_acc = acc_next[47:0];
        mix = $signed({2'b00, p_coef}) * p_smooth
            + $signed(18'(18'd65536 - p_coef)) * p_acc + 82'sd32768;
        p_smooth = 48'(mix >>> 16);
        pos = (p_wpos >= n) ? 0 : p_wpos;
        xoff = arr - p_first;
        p_hx[pos] = $signed(xoff);
        p_hy[pos] = p_smooth;
        pos++;
        p_wpos = (pos >= n) ? 0 : pos;
        if (p_fill < n)
            p_fill++;
        res.valid = (p_fill >= n);
        if (res.valid)
            p_fit = fit_trend(n);
        scaled = ($signed({1'b0, p_gain}) * p_fit) >>> 8;
        if (scaled > 64'sd2147483647)
            scaled = 64'sd2147483647;
        else if (scaled < -64'sd2147483648)
            scaled = -64'sd2147483648;
        res.slope = scaled[31:0];
        res.count = p_seen[15:0];
    endtask

    // wait until every result is in and the block has settled
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // register write while idle
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        drain();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        model_reg_write(idx, data);
        cfg_writes++;
    endtask

    // one item on the input channel, with an optional gap ahead of it
    task automatic send_item(input logic [31:0] recv, input logic [31:0] send,
                             input logic [47:0] arr, input bit typed,
                             input slope_result_t typed_res);
        slope_result_t res;
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        recv_spacing <= recv;
        send_spacing <= send;
        arrival_time <= arr;
        do
            @(posedge clk);
        while (!in_ready);
        trend_predict(recv, send, arr, res);
        pending_results.push_back(typed ? typed_res : res);
        items_sent++;
    endtask

    // table helpers
    function automatic void add_cfg(input logic [1:0] idx, input logic [15:0] data);
        stim_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        stim_table.push_back(row);
    endfunction

    function automatic void add_item(input logic [31:0] recv, input logic [31:0] send,
                                     input logic [47:0] arr, input bit typed,
                                     input logic [31:0] e_slope, input logic e_valid,
                                     input logic [15:0] e_count);
        stim_row_t row;
        row = '{default: '0};
        row.recv    = recv;
        row.send    = send;
        row.arrival = arr;
        row.typed   = typed;
        row.res     = '{slope: e_slope, valid: e_valid, count: e_count};
        stim_table.push_back(row);
    endfunction

    // receiver stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 11) == 0)
        begin
            stall_left <= $urandom_range(0, 7);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        slope_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: slope %h valid %b count %0d",
                         $time, scaled_slope, slope_valid, delta_count);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (slope_valid)
                    valid_results++;
                if (scaled_slope !== want.slope)
                begin
                    $display("%0t: scaled_slope expected %h actual %h",
                             $time, want.slope, scaled_slope);
                    errors++;
                end
                if (slope_valid !== want.valid)
                begin
                    $display("%0t: slope_valid expected %b actual %b",
                             $time, want.valid, slope_valid);
                    errors++;
                end
                if (delta_count !== want.count)
                begin
                    $display("%0t: delta_count expected %0d actual %0d",
                             $time, want.count, delta_count);
                    errors++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic [31:0] r;
        logic [31:0] s;
        logic [47:0] arr;
        logic [15:0] wv;
        int          kind;
        slope_result_t none;

        none         = '{default: '0};
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        recv_spacing = '0;
        send_spacing = '0;
        arrival_time = '0;
        out_ready    = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        quiet        = 1'b0;
        stall_left   = 0;
        errors = 0; items_sent = 0; results_checked = 0; cfg_writes = 0; valid_results = 0;

        p_coef = RST_SMOOTHING_COEF; p_gain = RST_THRESHOLD_GAIN;
        p_window = RST_WINDOW_LENGTH; p_limit = RST_COUNT_LIMIT;
        p_acc = '0; p_smooth = '0; p_first = '0; p_first_seen = 1'b0;
        p_wpos = 0; p_fill = 0; p_fit = '0; p_seen = '0;
        for (int k = 0; k < MAXW; k++)
        begin
            p_hx[k] = '0;
            p_hy[k] = '0;
        end

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // directed table
        add_item(32'h0000_0100, 32'h0, 48'd1000, 1, 32'h0, 1'b0, 16'd1);
        add_cfg(REG_WINDOW_LENGTH, 16'h0000);        // below range, acts as two
        add_cfg(REG_COUNT_LIMIT, 16'h0000);          // zero count limit
        add_item(32'h0000_0200, 32'h0000_0080, 48'd1000, 1, 32'h0, 1'b0, 16'd0);
        add_item(32'h0, 32'h0, 48'd1000, 1, 32'h0, 1'b1, 16'd0);  // zero x variance
        add_cfg(REG_COUNT_LIMIT, 16'h0001);
        add_item(32'h7FFF_FFFF, 32'h8000_0000, 48'd1001, 0, 32'h0, 1'b0, 16'd0);
        add_item(32'h8000_0000, 32'h7FFF_FFFF, 48'd1002, 0, 32'h0, 1'b0, 16'd0);
        add_cfg(REG_THRESHOLD_GAIN, 16'h0000);
        add_item(32'h0000_1000, 32'h0, 48'd1010, 1, 32'h0, 1'b1, 16'd1);
        add_cfg(REG_THRESHOLD_GAIN, 16'hFFFF);
        add_item(32'h7FFF_FFFF, 32'h0, 48'd1011, 0, 32'h0, 1'b0, 16'd0);
        add_cfg(REG_SMOOTHING_COEF, 16'h0000);
        add_item(32'h0, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 0, 32'h0, 1'b0, 16'd0);
        add_item(32'hFFFF_FFFF, 32'h0000_0001, 48'd0, 0, 32'h0, 1'b0, 16'd0);
        add_cfg(REG_SMOOTHING_COEF, 16'hFFFF);
        add_cfg(REG_COUNT_LIMIT, 16'hFFFF);
        add_cfg(REG_WINDOW_LENGTH, 16'hFF7F);        // above range, acts as the maximum
        for (int k = 0; k < 8; k++)
            add_item(32'h0000_0040 * k, 32'h20, 48'd1100 + 48'd3 * k, 0, 32'h0, 1'b0, 16'd0);
        add_cfg(REG_WINDOW_LENGTH, 16'h0003);
        add_cfg(REG_THRESHOLD_GAIN, 16'h0100);
        for (int k = 0; k < 4; k++)
            add_item(32'h0000_0300, 32'h0000_0100 * k, 48'd1200 + 48'd7 * k,
                     0, 32'h0, 1'b0, 16'd0);

        foreach (stim_table[i])
        begin
            if (stim_table[i].is_cfg)
                write_reg(stim_table[i].idx, stim_table[i].data);
            else
                send_item(stim_table[i].recv, stim_table[i].send, stim_table[i].arrival,
                          stim_table[i].typed, stim_table[i].res);
        end

        // random phases, each under its own register setting
        arr = 48'd5000;
        for (int ph = 0; ph < 8; ph++)
        begin
            quiet = (ph == 7) || (ph == 3);
            case (ph)
                0: wv = 16'd2;
                1: wv = 16'd64;
                2: wv = {9'($urandom_range(0, 511)), 7'($urandom_range(0, 127))};
                default: wv = 16'($urandom_range(2, 24));
            endcase
            write_reg(REG_WINDOW_LENGTH, wv);
            write_reg(REG_SMOOTHING_COEF, (ph == 4) ? 16'h0000 :
                                          (ph == 5) ? 16'hFFFF : 16'($urandom));
            write_reg(REG_THRESHOLD_GAIN, (ph == 6) ? 16'hFFFF : 16'($urandom));
            write_reg(REG_COUNT_LIMIT, ($urandom_range(0, 1) == 0) ?
                      16'($urandom_range(0, 300)) : 16'($urandom));
            for (int k = 0; k < 250; k++)
            begin
                kind = $urandom_range(0, 19);
                if (kind == 0)
                begin
                    r   = $urandom;
                    s   = $urandom;
                    arr = {16'($urandom), 32'($urandom)};
                end
                else
                begin
                    r = 32'($signed($urandom_range(0, 6000)) - 3000);
                    s = 32'($signed($urandom_range(0, 6000)) - 3000);
                    if (kind != 1)
                        arr = arr + 48'($urandom_range(1, 40));
                end
                send_item(r, s, arr, 0, none);
            end
        end

        drain();
        repeat (200) @(posedge clk);
        $display("ran %0d items and %0d register writes; %0d results checked, %0d with a fit",
                 items_sent, cfg_writes, results_checked, valid_results);
        $display("windows from two to the maximum, extreme coefficients, gains and limits");
        if (errors == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ delay_trendline_slope_estimator_top.f @@
+incdir+hw/rtl
hw/rtl/dts_pkg.sv
hw/rtl/dts_front.sv
hw/rtl/dts_queue.sv
hw/rtl/dts_mul.sv
hw/rtl/dts_back.sv
hw/rtl/delay_trendline_slope_estimator_top.sv
verif/delay_trendline_slope_estimator_top_tb.sv
